>>> rtl/act_pkg.sv
// act_pkg: shared types and constants for the associative counter table
// used by act_cell and associative_counter_table_unit; no dependencies
`default_nettype none

package act_pkg;

    // command codes
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam int unsigned KEY_W   = 32;
    localparam int unsigned VALUE_W = 32;
    localparam int unsigned COUNT_W = 16;

    // input request payload
    typedef struct packed {
        logic                      command;
        logic signed [KEY_W-1:0]   key;
        logic signed [VALUE_W-1:0] value;
    } in_item_t;

    // result payload
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               found;
    } out_item_t;

    // request as broadcast to every cell
    typedef struct packed {
        logic               fire;
        logic               is_write;
        logic [KEY_W-1:0]   key;
        logic [COUNT_W-1:0] wval;
    } cell_req_t;

    // lookup result passed from cell to cell
    typedef struct packed {
        logic               hit;
        logic [COUNT_W-1:0] count;
    } chain_t;

    // values outside 0..65535 become zero
    function automatic logic [COUNT_W-1:0] clamp_value(input logic [VALUE_W-1:0] raw);
        logic [COUNT_W-1:0] res;
        res = '0;
        if (raw[VALUE_W-1:COUNT_W] == '0)
        begin
            res = raw[COUNT_W-1:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/act_cell.sv
// act_cell: one table entry (key and counter) with its compare logic
// depends on act_pkg
`default_nettype none

module act_cell (
    input  wire                        clk,
    input  wire                        rst_n,
    input  wire act_pkg::cell_req_t    req,
    input  wire                        claim,
    input  wire act_pkg::chain_t       chain_in,
    output act_pkg::chain_t            chain_out
);

    logic [act_pkg::KEY_W-1:0]   key_reg;
    logic [act_pkg::KEY_W-1:0]   key_next;
    logic [act_pkg::COUNT_W-1:0] count_reg;
    logic [act_pkg::COUNT_W-1:0] count_next;
    logic                        match;
    logic                        first_hit;

    // compare and priority: an entry above that hit wins
    assign match     = (key_reg == req.key);
    assign first_hit = match && !chain_in.hit;

    always_comb
    begin
        chain_out.hit   = chain_in.hit || match;
        chain_out.count = first_hit ? count_reg : chain_in.count;
    end

    // entry update on a write hit or on a claim
    always_comb
    begin
        key_next   = key_reg;
        count_next = count_reg;
        if (claim)
        begin
            key_next   = req.key;
            count_next = req.is_write ? req.wval : '0;
        end
        else if (req.fire && req.is_write && first_hit)
        begin
            count_next = req.wval;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            key_reg   <= key_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/associative_counter_table_unit.sv
// associative_counter_table_unit: top level, request register, row of cells,
// round-robin replacement pointer and result register; depends on act_pkg, act_cell
//
// usage:
// - input channel in_valid / in_stall / in_req carries a request: command
//   (read or write), key and value. output channel out_valid / out_stall /
//   out_rsp carries one result per request: count and found.
// - a request is first held in a request register, then, once the result
//   register is free or being read, it runs down the row of cells (lowest
//   matching entry wins), updates the table and lands in the result register.
// - throughput is one request per cycle while out_stall holds no result: a new
//   request is taken in the cycle the held one executes; the compare ripple
//   through the cell row sets the cycle time.
// - on a miss the entry at the replacement pointer is claimed and the
//   pointer advances, wrapping after ENTRIES - 1.
// - reset clears all keys and counts to zero and the pointer to zero, so
//   key 0 hits entry 0 at first.
// - when out_stall holds a result, the held request waits, and in_stall
//   rises once the request register is full; nothing is dropped.
`default_nettype none

module associative_counter_table_unit #(
    parameter int unsigned ENTRIES = 8
) (
    input  wire                       clk,
    input  wire                       rst_n,
    input  wire                       in_valid,
    output logic                      in_stall,
    input  wire act_pkg::in_item_t    in_req,
    output logic                      out_valid,
    input  wire                       out_stall,
    output act_pkg::out_item_t        out_rsp
);

    localparam int unsigned PTR_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    logic                     req_valid_reg;
    logic                     req_valid_next;
    act_pkg::in_item_t        req_reg;
    logic [PTR_W-1:0]         ptr_reg;
    logic [PTR_W-1:0]         ptr_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    act_pkg::out_item_t       out_reg;
    logic                     fire;
    logic                     accept;
    act_pkg::cell_req_t       cell_req;
    act_pkg::chain_t          chain [ENTRIES+1];
    logic [ENTRIES-1:0]       claim;
    logic                     miss;

    // handshake
    assign fire     = req_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && !fire;
    assign accept   = in_valid && !in_stall;
    assign miss     = !chain[ENTRIES].hit;

    // broadcast request to the cells
    always_comb
    begin
        cell_req.fire     = fire;
        cell_req.is_write = (req_reg.command == act_pkg::CMD_WRITE);
        cell_req.key      = req_reg.key;
        cell_req.wval     = act_pkg::clamp_value(req_reg.value);
    end

    assign chain[0] = '0;

    // row of cells
    for (genvar i = 0; i < ENTRIES; i++)
    begin : g_cell
        assign claim[i] = fire && miss && (ptr_reg == PTR_W'(i));

        act_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .req       (cell_req),
            .claim     (claim[i]),
            .chain_in  (chain[i]),
            .chain_out (chain[i+1])
        );
    end

    // request register valid
    always_comb
    begin
        req_valid_next = req_valid_reg;
        if (accept)
        begin
            req_valid_next = 1'b1;
        end
        else if (fire)
        begin
            req_valid_next = 1'b0;
        end
    end

    // replacement pointer
    always_comb
    begin
        ptr_next = ptr_reg;
        if (fire && miss)
        begin
            ptr_next = (ptr_reg == PTR_W'(ENTRIES - 1)) ? '0 : ptr_reg + PTR_W'(1);
        end
    end

    // result register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            req_valid_reg <= req_valid_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= in_req;
        end
        if (fire)
        begin
            out_reg.found <= chain[ENTRIES].hit;
            if (miss)
            begin
                out_reg.count <= cell_req.is_write ? cell_req.wval : '0;
            end
            else
            begin
                out_reg.count <= cell_req.is_write ? cell_req.wval : chain[ENTRIES].count;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_rsp   = out_reg;

    // a hit leaves the replacement pointer alone
    a_hit_keeps_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !miss |=> $stable(ptr_reg))
        else $error("pointer moved on a hit");

    // pointer stays within the table
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_W'(ENTRIES - 1))
        else $error("pointer out of range");

    // a miss claims exactly one entry
    a_one_claim: assert property (@(posedge clk) disable iff (!rst_n)
        fire && miss |-> $onehot(claim))
        else $error("miss did not claim exactly one entry");

    // a write returns the stored value
    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && cell_req.is_write |=> out_reg.count == $past(cell_req.wval))
        else $error("write result mismatch");

    // executing a request always yields a result
    a_fire_result: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> out_valid_reg)
        else $error("result lost");

endmodule

`default_nettype wire

>>> tb/tb_associative_counter_table_unit.sv
// tb_associative_counter_table_unit: self-checking bench for the associative counter table
// mirrors the lookup, claim and round-robin replacement in its own table copy
// depends on act_pkg and associative_counter_table_unit
`default_nettype none

module tb_associative_counter_table_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ENTRIES      = 8;
    localparam int POOL_SIZE    = 12;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 10;

    // one row of the directed table; expected result used only when pinned
    typedef struct packed {
        logic        command;
        logic [31:0] key;
        logic [31:0] value;
        logic        pinned;
        logic [15:0] count;
        logic        found;
    } directed_row_t;

    localparam int DIRECTED_ROWS = 25;
    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // key zero hits entry 0 right after reset
        '{act_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b1},
        '{act_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_ffff, 1'b1, 16'd65535, 1'b1},
        '{act_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 1'b1, 16'd65535, 1'b1},
        // out of range values store zero
        '{act_pkg::CMD_WRITE, 32'h0000_0000, 32'h0001_0000, 1'b1, 16'd0,     1'b1},
        '{act_pkg::CMD_WRITE, 32'h0000_0000, 32'hffff_ffff, 1'b1, 16'd0,     1'b1},
        '{act_pkg::CMD_WRITE, 32'h0000_0000, 32'h8000_0000, 1'b1, 16'd0,     1'b1},
        '{act_pkg::CMD_WRITE, 32'h0000_0000, 32'h7fff_ffff, 1'b1, 16'd0,     1'b1},
        '{act_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_0001, 1'b1, 16'd1,     1'b1},
        // read miss claims entry 0, value ignored on read
        '{act_pkg::CMD_READ,  32'h7fff_ffff, 32'hffff_ffff, 1'b1, 16'd0,     1'b0},
        // duplicate zero keys: entry 1 now wins
        '{act_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b1},
        '{act_pkg::CMD_WRITE, 32'h8000_0000, 32'h0000_ffff, 1'b1, 16'd65535, 1'b0},
        '{act_pkg::CMD_WRITE, 32'h0000_0000, 32'h0000_002a, 1'b1, 16'd42,    1'b1},
        '{act_pkg::CMD_READ,  32'hffff_ffff, 32'h0000_0000, 1'b1, 16'd0,     1'b0},
        '{act_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 1'b1, 16'd0,     1'b1},
        '{act_pkg::CMD_READ,  32'h8000_0000, 32'h0000_0000, 1'b1, 16'd65535, 1'b1},
        // fill the rest of the table and wrap the pointer
        '{act_pkg::CMD_WRITE, 32'h7fff_ffff, 32'h0000_3039, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_WRITE, 32'h0000_0011, 32'h0000_0064, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_READ,  32'h0000_0022, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_WRITE, 32'h0000_0033, 32'h0001_0000, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_WRITE, 32'h0000_0044, 32'h0000_0007, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_WRITE, 32'h0000_0055, 32'h0000_0009, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_READ,  32'h0000_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_READ,  32'h7fff_ffff, 32'h0000_0000, 1'b0, 16'd0,     1'b0},
        '{act_pkg::CMD_READ,  32'h8000_0000, 32'h0000_0000, 1'b0, 16'd0,     1'b0}
    };

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    act_pkg::in_item_t  in_req;
    logic               out_valid;
    logic               out_stall;
    act_pkg::out_item_t out_rsp;

    // side info travelling with the request being offered
    logic               row_pinned;
    act_pkg::out_item_t row_result;

    // shadow copy of the table
    logic [31:0] shadow_key   [ENTRIES];
    logic [15:0] shadow_count [ENTRIES];
    int          victim;

    act_pkg::out_item_t pending_counts [$];
    logic [31:0]        key_pool [POOL_SIZE];

    int sender_gap_pct;
    int recv_stall_pct;
    int holds_asked;
    int holds_done;
    int hold_left;

    int cycles;
    int accepted;
    int directed_done;
    int hits;
    int claims;
    int blocked_cycles;
    int mismatches;
    int error_count;

    associative_counter_table_unit #(.ENTRIES(ENTRIES)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_rsp   (out_rsp)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #6 clk = ~clk;
        end
    end

    // lookup with lowest match winning, claim at the pointer on a miss
    function automatic act_pkg::out_item_t table_access(act_pkg::in_item_t req);
        act_pkg::out_item_t rsp;
        int                 hit;
        logic [15:0]        wval;
        hit = -1;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (shadow_key[i] == req.key)
                hit = i;
        end
        wval = (req.value[31:16] == 16'h0000) ? req.value[15:0] : 16'h0000;
        if (hit >= 0)
        begin
            if (req.command == act_pkg::CMD_WRITE)
                shadow_count[hit] = wval;
            rsp.count = shadow_count[hit];
            rsp.found = 1'b1;
        end
        else
        begin
            shadow_key[victim]   = req.key;
            shadow_count[victim] = (req.command == act_pkg::CMD_WRITE) ? wval : 16'h0000;
            rsp.count = shadow_count[victim];
            rsp.found = 1'b0;
            victim = (victim == ENTRIES - 1) ? 0 : victim + 1;
        end
        return rsp;
    endfunction

    function automatic void note_mismatch(string what, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch %s at cycle %0d: expected %0h, got %0h",
                     what, cycles, exp_v, act_v);
    endfunction

    // random request: keys mostly from a small pool so hits and evictions mix
    function automatic act_pkg::in_item_t random_request();
        act_pkg::in_item_t req;
        int                pick;
        req.command = ($urandom_range(0, 1) == 0) ? act_pkg::CMD_READ : act_pkg::CMD_WRITE;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            req.key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        else if (pick < 80)
            req.key = 32'h0000_0000;
        else
            req.key = $urandom;
        pick = $urandom_range(0, 99);
        if (pick < 60)
            req.value = $urandom_range(0, 65535);
        else if (pick < 75)
        begin
            case ($urandom_range(0, 5))
                0: req.value = 32'h0000_0000;
                1: req.value = 32'h0000_ffff;
                2: req.value = 32'h0001_0000;
                3: req.value = 32'hffff_ffff;
                4: req.value = 32'h8000_0000;
                default: req.value = 32'h7fff_ffff;
            endcase
        end
        else
            req.value = $urandom;
        return req;
    endfunction

    // offer one request, wait for it to be taken, then maybe go idle
    task automatic offer(act_pkg::in_item_t req, logic pinned, act_pkg::out_item_t pinned_rsp);
        int gap;
        in_valid   <= 1'b1;
        in_req     <= req;
        row_pinned <= pinned;
        row_result <= pinned_rsp;
        do
            @(posedge clk);
        while (in_stall);
        gap = 0;
        while ($urandom_range(0, 99) < sender_gap_pct)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic run_random(int n, int gap_pct, int stall_pct);
        act_pkg::out_item_t none;
        none = '0;
        // go idle and pause until the table has answered everything
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        sender_gap_pct = gap_pct;
        recv_stall_pct = stall_pct;
        repeat (n) offer(random_request(), 1'b0, none);
    endtask

    // receiver: random stalls, plus long hold-offs on demand
    initial
    begin
        out_stall <= 1'b0;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (hold_left == 0 && holds_done != holds_asked)
            begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // predict on each taken request, check each taken result
    always @(posedge clk)
    begin
        act_pkg::out_item_t predicted;
        act_pkg::out_item_t exp_rsp;
        if (rst_n)
        begin
            if (in_valid && in_stall)
                blocked_cycles++;
            if (in_valid && !in_stall)
            begin
                predicted = table_access(in_req);
                pending_counts.push_back(row_pinned ? row_result : predicted);
                accepted++;
            end
            if (out_valid && !out_stall)
            begin
                if (pending_counts.size() == 0)
                begin
                    error_count++;
                    note_mismatch("unexpected result", 32'h0,
                                  {15'h0, out_rsp.count, out_rsp.found});
                end
                else
                begin
                    exp_rsp = pending_counts.pop_front();
                    if (out_rsp.count !== exp_rsp.count)
                        note_mismatch("count", 32'(exp_rsp.count), 32'(out_rsp.count));
                    if (out_rsp.found !== exp_rsp.found)
                        note_mismatch("found", 32'(exp_rsp.found), 32'(out_rsp.found));
                    if (out_rsp.found === 1'b1)
                        hits++;
                    else
                        claims++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     pending_counts.size());
            $display("status: fail");
            $finish;
        end
    end

    // main sequence
    initial
    begin
        act_pkg::out_item_t fixed_rsp;
        act_pkg::in_item_t  req;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        in_req         <= '0;
        row_pinned     <= 1'b0;
        row_result     <= '0;
        sender_gap_pct = 0;
        recv_stall_pct = 0;
        holds_asked    = 0;
        holds_done     = 0;
        cycles         = 0;
        accepted       = 0;
        directed_done  = 0;
        hits           = 0;
        claims         = 0;
        blocked_cycles = 0;
        mismatches     = 0;
        error_count    = 0;
        victim         = 0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            shadow_key[i]   = 32'h0;
            shadow_count[i] = 16'h0;
        end
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'h7fff_ffff;
        key_pool[2] = 32'h8000_0000;
        key_pool[3] = 32'hffff_ffff;
        for (int i = 4; i < POOL_SIZE; i++)
            key_pool[i] = $urandom;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            req.command     = DIRECTED[r].command;
            req.key         = DIRECTED[r].key;
            req.value       = DIRECTED[r].value;
            fixed_rsp.count = DIRECTED[r].count;
            fixed_rsp.found = DIRECTED[r].found;
            offer(req, DIRECTED[r].pinned, fixed_rsp);
        end
        directed_done = DIRECTED_ROWS;

        // random phases: free flow, idle sender, stalling receiver, both
        run_random(200, 0, 0);
        run_random(160, 75, 0);
        run_random(160, 0, 75);
        run_random(160, 37, 37);

        // long receiver hold-off while the sender keeps pushing
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        holds_asked++;
        run_random(120, 0, 0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_counts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d requests (%0d directed): %0d hits, %0d claims, %0d mismatches",
                 accepted, directed_done, hits, claims, mismatches + error_count);
        $display("input held back for %0d cycles across idle, stall and hold-off phases",
                 blocked_cycles);
        if (mismatches == 0 && error_count == 0 && pending_counts.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
